// ===== hdl/reno_window_and_rto_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Reno window / RTO tracker assertion macros
// Shared assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RENO_WINDOW_AND_RTO_TRACKER_DEFINES_SVH
`define RENO_WINDOW_AND_RTO_TRACKER_DEFINES_SVH

// same-cycle implication
`define RWRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwrt: same-cycle check failed");

// next-cycle implication
`define RWRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwrt: next-cycle check failed");

`endif

// ===== hdl/rwrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwrt_pkg
// Types, constants and helpers for the Reno window / RTO tracker.
// ----------------------------------------------------------------------------
package rwrt_pkg;

  localparam int WIN_W          = 16;
  localparam int TIME_W         = 24;
  localparam int THR_W          = 8;
  localparam int ACTION_W       = 3;
  localparam int ERR_GAIN_SHIFT = 3;
  localparam int DEV_GAIN_SHIFT = 2;

  localparam logic [WIN_W-1:0]  WIN_MAX  = {WIN_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RTT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTO       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD = 2'd3;

  localparam logic [WIN_W-1:0]  RST_REMOTE_WINDOW = 16'd2;
  localparam logic [TIME_W-1:0] RST_INITIAL_RTT   = 24'd1000000;
  localparam logic [TIME_W-1:0] RST_MAX_RTO       = 24'd3000000;
  localparam logic [THR_W-1:0]  RST_DUP_THRESHOLD = 8'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [ACTION_W-1:0] ACT_SEND    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ACK     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOSS    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RETX    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_DUP     = 3'd5;

  typedef enum logic [2:0] {
    EV_SEND,
    EV_ACK,
    EV_LOSS,
    EV_RETX,
    EV_TIMEOUT,
    EV_DUP,
    EV_NOP
  } evt_t;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_NORMAL,
    MODE_FAST,
    MODE_TIMEOUT
  } mode_t;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_SRTT,
    PH_DEV,
    PH_RTO
  } phase_t;

  typedef struct packed {
    evt_t              kind;
    logic              sample;
    logic [TIME_W-1:0] rtt;
  } item_t;

  function automatic logic [WIN_W-1:0] win_inc(input logic [WIN_W-1:0] v);
    return (v == WIN_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [WIN_W-1:0] win_dec(input logic [WIN_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] clamp_rto(input logic [TIME_W+2:0] v,
                                                  input logic [TIME_W-1:0] mx);
    return (v > {3'b000, mx}) ? mx : v[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] initial_rto(input logic [TIME_W-1:0] irtt);
    logic [TIME_W-1:0] dev;
    logic [TIME_W+1:0] sum;
    dev = irtt >> DEV_GAIN_SHIFT;
    sum = {2'b00, irtt} + {dev, 2'b00};
    return (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  localparam logic [TIME_W-1:0] RST_DEV = RST_INITIAL_RTT >> DEV_GAIN_SHIFT;
  localparam logic [TIME_W-1:0] RST_RTO = initial_rto(RST_INITIAL_RTT);

endpackage

// ===== hdl/rwrt_event_if.sv =====
// ----------------------------------------------------------------------------
// rwrt_event_if / rwrt_result_if
// Valid/ready channels for events in and status results out.
// ----------------------------------------------------------------------------
interface rwrt_event_if import rwrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TIME_W-1:0]   rtt_sample;

  modport source(output valid, action, rtt_sample, input ready);
  modport sink(input valid, action, rtt_sample, output ready);
endinterface

interface rwrt_result_if import rwrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WIN_W-1:0]  usable_window;
  logic [WIN_W-1:0]  packets_in_flight;
  logic [TIME_W-1:0] smoothed_rtt;
  logic [TIME_W-1:0] retransmit_timeout;
  logic [TIME_W-1:0] send_wait;
  logic [1:0]        cc_mode;

  modport source(output valid, usable_window, packets_in_flight, smoothed_rtt,
                 retransmit_timeout, send_wait, cc_mode, input ready);
  modport sink(input valid, usable_window, packets_in_flight, smoothed_rtt,
               retransmit_timeout, send_wait, cc_mode, output ready);
endinterface

// ===== hdl/rwrt_front.sv =====
// ----------------------------------------------------------------------------
// rwrt_front
// Input stage: takes event transfers, decodes the action, flags RTT samples.
// ----------------------------------------------------------------------------
module rwrt_front import rwrt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  rwrt_event_if.sink in_ch,
  output logic  item_valid,
  output item_t item,
  input  logic  item_ready
);

  logic  hold_valid_r, hold_valid_nxt;
  item_t hold_r;
  item_t dec;
  logic  take;

  always_comb begin
    case (in_ch.action)
      ACT_SEND:    dec.kind = EV_SEND;
      ACT_ACK:     dec.kind = EV_ACK;
      ACT_LOSS:    dec.kind = EV_LOSS;
      ACT_RETX:    dec.kind = EV_RETX;
      ACT_TIMEOUT: dec.kind = EV_TIMEOUT;
      ACT_DUP:     dec.kind = EV_DUP;
      default:     dec.kind = EV_NOP;
    endcase
    dec.sample = (in_ch.action == ACT_ACK) && (in_ch.rtt_sample != '0);
    dec.rtt    = in_ch.rtt_sample;
  end

  assign in_ch.ready = !hold_valid_r || item_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (take) begin
      hold_valid_nxt = 1'b1;
    end else if (item_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= dec;
    end
  end

  assign item_valid = hold_valid_r;
  assign item       = hold_r;

endmodule

// ===== hdl/rwrt_fifo.sv =====
// ----------------------------------------------------------------------------
// rwrt_fifo
// Short event queue between the decode stage and the state update.
// ----------------------------------------------------------------------------
module rwrt_fifo import rwrt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  item_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 push, pop;

  assign push_ready = (count_r != FIFO_DEPTH[FIFO_AW:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/rwrt_back.sv =====
// ----------------------------------------------------------------------------
// rwrt_back
// Sender state update: in-flight count, Reno window modes, RTT/RTO estimator,
// configuration registers and the registered result stage.
// ----------------------------------------------------------------------------
module rwrt_back import rwrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  item_t                 item,
  output logic                  item_ready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rwrt_result_if.source         out_ch
);

  logic [WIN_W-1:0]  remote_r, remote_nxt;
  logic [TIME_W-1:0] init_rtt_r, init_rtt_nxt;
  logic [TIME_W-1:0] max_rto_r, max_rto_nxt;
  logic [THR_W-1:0]  dup_thr_r, dup_thr_nxt;

  logic [TIME_W-1:0] srtt_r, srtt_nxt;
  logic [TIME_W-1:0] dev_r, dev_nxt;
  logic [TIME_W-1:0] rto_r, rto_nxt;
  logic [WIN_W-1:0]  inflight_r, inflight_nxt;
  logic [WIN_W-1:0]  cwnd_r, cwnd_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [WIN_W-1:0]  ssthr_r, ssthr_nxt;
  mode_t             mode_r, mode_nxt;
  logic [WIN_W-1:0]  dup_r, dup_nxt;
  logic [WIN_W-1:0]  ackc_r, ackc_nxt;
  phase_t            phase_r, phase_nxt;

  logic signed [TIME_W:0] err_r, err_nxt;
  logic [TIME_W-1:0]      mag_r, mag_nxt;
  logic signed [TIME_W:0] dv_r, dv_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]       o_win_r, o_inflight_r;
  logic [TIME_W-1:0]      o_srtt_r, o_rto_r, o_wait_r;
  mode_t                  o_mode_r;

  logic                   out_free, take, is_sample, emit, refresh;
  logic [WIN_W-1:0]       rw_eff, ackc_inc, dup_inc, half_win;
  logic [WIN_W:0]         retx_cw;
  logic signed [TIME_W:0] srtt_upd, dev_upd, err_new;
  logic [TIME_W+2:0]      rto_sum;
  logic [TIME_W-1:0]      wait_nxt;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign item_ready = (phase_r == PH_RUN) && out_free;
  assign take       = item_valid && item_ready;
  assign is_sample  = (item.kind == EV_ACK) && item.sample;
  assign emit       = (take && !is_sample) || ((phase_r == PH_RTO) && out_free);

  assign rw_eff   = (remote_r == '0) ? {{(WIN_W-1){1'b0}}, 1'b1} : remote_r;
  assign ackc_inc = win_inc(ackc_r);
  assign dup_inc  = win_inc(dup_r);
  assign half_win = win_r >> 1;
  assign retx_cw  = {1'b0, ((half_win < 2) ? WIN_W'(2) : half_win)} + (WIN_W+1)'(3);
  assign err_new  = $signed({1'b0, item.rtt}) - $signed({1'b0, srtt_r});
  assign srtt_upd = $signed({1'b0, srtt_r}) + (err_r >>> ERR_GAIN_SHIFT);
  assign dev_upd  = $signed({1'b0, dev_r}) + (dv_r >>> DEV_GAIN_SHIFT);
  assign rto_sum  = {3'b000, srtt_r} + {1'b0, dev_r, 2'b00};

  // sequencer for RTT samples
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_RUN: begin
        if (take && is_sample) begin
          phase_nxt = (srtt_r == '0) ? PH_RTO : PH_SRTT;
        end
      end
      PH_SRTT: phase_nxt = PH_DEV;
      PH_DEV:  phase_nxt = PH_RTO;
      PH_RTO: begin
        if (out_free) begin
          phase_nxt = PH_RUN;
        end
      end
      default: phase_nxt = PH_RUN;
    endcase
  end

  // state update
  always_comb begin
    remote_nxt   = remote_r;
    init_rtt_nxt = init_rtt_r;
    max_rto_nxt  = max_rto_r;
    dup_thr_nxt  = dup_thr_r;
    srtt_nxt     = srtt_r;
    dev_nxt      = dev_r;
    rto_nxt      = rto_r;
    inflight_nxt = inflight_r;
    cwnd_nxt     = cwnd_r;
    ssthr_nxt    = ssthr_r;
    mode_nxt     = mode_r;
    dup_nxt      = dup_r;
    ackc_nxt     = ackc_r;
    err_nxt      = err_r;
    mag_nxt      = mag_r;
    dv_nxt       = dv_r;
    refresh      = 1'b0;

    case (phase_r)
      PH_RUN: begin
        if (take) begin
          case (item.kind)
            EV_SEND: inflight_nxt = win_inc(inflight_r);
            EV_LOSS: inflight_nxt = win_dec(inflight_r);
            EV_ACK: begin
              inflight_nxt = win_dec(inflight_r);
              dup_nxt      = '0;
              ackc_nxt     = ackc_inc;
              refresh      = 1'b1;
              case (mode_r)
                MODE_START, MODE_TIMEOUT: begin
                  cwnd_nxt = win_inc(cwnd_r);
                  if (cwnd_nxt == ssthr_r) begin
                    mode_nxt = MODE_NORMAL;
                  end
                end
                MODE_FAST: begin
                  mode_nxt = MODE_NORMAL;
                  cwnd_nxt = ssthr_r;
                end
                default: begin
                  if (ackc_inc >= cwnd_r) begin
                    ackc_nxt = '0;
                    cwnd_nxt = win_inc(cwnd_r);
                  end
                end
              endcase
              if (item.sample) begin
                if (srtt_r == '0) begin
                  srtt_nxt = item.rtt;
                  dev_nxt  = item.rtt >> 1;
                end else begin
                  err_nxt = err_new;
                  mag_nxt = err_new[TIME_W] ? TIME_W'(-err_new) : err_new[TIME_W-1:0];
                end
              end
            end
            EV_RETX: begin
              ssthr_nxt = retx_cw[WIN_W-1:0] - WIN_W'(3);
              ackc_nxt  = '0;
              refresh   = 1'b1;
              if (mode_r != MODE_TIMEOUT && mode_r != MODE_FAST) begin
                mode_nxt = MODE_FAST;
                cwnd_nxt = retx_cw[WIN_W] ? WIN_MAX : retx_cw[WIN_W-1:0];
              end
            end
            EV_TIMEOUT: begin
              rto_nxt  = clamp_rto({2'b00, rto_r, 1'b0}, max_rto_r);
              mode_nxt = MODE_TIMEOUT;
              cwnd_nxt = {{(WIN_W-1){1'b0}}, 1'b1};
              refresh  = 1'b1;
            end
            EV_DUP: begin
              dup_nxt = dup_inc;
              if (dup_inc > {{(WIN_W-THR_W){1'b0}}, dup_thr_r} && mode_r == MODE_FAST) begin
                cwnd_nxt = win_inc(cwnd_r);
                refresh  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      PH_SRTT: begin
        srtt_nxt = srtt_upd[TIME_W-1:0];
        dv_nxt   = $signed({1'b0, mag_r}) - $signed({1'b0, dev_r});
      end
      PH_DEV: dev_nxt = dev_upd[TIME_W-1:0];
      PH_RTO: rto_nxt = clamp_rto(rto_sum, max_rto_r);
      default: ;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_REMOTE_WINDOW: remote_nxt = cfg_data[WIN_W-1:0];
        CFG_INITIAL_RTT: begin
          init_rtt_nxt = cfg_data[TIME_W-1:0];
          if (srtt_r == '0) begin
            dev_nxt = cfg_data[TIME_W-1:0] >> DEV_GAIN_SHIFT;
            rto_nxt = initial_rto(cfg_data[TIME_W-1:0]);
          end
        end
        CFG_MAX_RTO:       max_rto_nxt = cfg_data[TIME_W-1:0];
        CFG_DUP_THRESHOLD: dup_thr_nxt = cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign win_nxt  = refresh ? ((cwnd_nxt > rw_eff) ? rw_eff : cwnd_nxt) : win_r;
  assign wait_nxt = (inflight_nxt < win_nxt) ? '0 : ((srtt_nxt != '0) ? srtt_nxt : rto_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_r    <= RST_REMOTE_WINDOW;
      init_rtt_r  <= RST_INITIAL_RTT;
      max_rto_r   <= RST_MAX_RTO;
      dup_thr_r   <= RST_DUP_THRESHOLD;
      srtt_r      <= '0;
      dev_r       <= RST_DEV;
      rto_r       <= RST_RTO;
      inflight_r  <= '0;
      cwnd_r      <= {{(WIN_W-1){1'b0}}, 1'b1};
      win_r       <= {{(WIN_W-1){1'b0}}, 1'b1};
      ssthr_r     <= '0;
      mode_r      <= MODE_START;
      dup_r       <= '0;
      ackc_r      <= '0;
      phase_r     <= PH_RUN;
      out_valid_r <= 1'b0;
    end else begin
      remote_r    <= remote_nxt;
      init_rtt_r  <= init_rtt_nxt;
      max_rto_r   <= max_rto_nxt;
      dup_thr_r   <= dup_thr_nxt;
      srtt_r      <= srtt_nxt;
      dev_r       <= dev_nxt;
      rto_r       <= rto_nxt;
      inflight_r  <= inflight_nxt;
      cwnd_r      <= cwnd_nxt;
      win_r       <= win_nxt;
      ssthr_r     <= ssthr_nxt;
      mode_r      <= mode_nxt;
      dup_r       <= dup_nxt;
      ackc_r      <= ackc_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    mag_r <= mag_nxt;
    dv_r  <= dv_nxt;
    if (emit) begin
      o_win_r      <= win_nxt;
      o_inflight_r <= inflight_nxt;
      o_srtt_r     <= srtt_nxt;
      o_rto_r      <= rto_nxt;
      o_wait_r     <= wait_nxt;
      o_mode_r     <= mode_nxt;
    end
  end

  // init_rtt_r is held for the register map only
  assign out_ch.valid              = out_valid_r;
  assign out_ch.usable_window      = o_win_r;
  assign out_ch.packets_in_flight  = o_inflight_r;
  assign out_ch.smoothed_rtt       = o_srtt_r;
  assign out_ch.retransmit_timeout = o_rto_r;
  assign out_ch.send_wait          = o_wait_r;
  assign out_ch.cc_mode            = o_mode_r;

endmodule

// ===== hdl/reno_window_and_rto_tracker.sv =====
// ----------------------------------------------------------------------------
// reno_window_and_rto_tracker
// Per-path TCP Reno sender state with a smoothed RTT / RTO estimator.
// ----------------------------------------------------------------------------
// Every event transfer yields exactly one status transfer, in order. Events
// pass an input register and a four-entry queue before the state update, so
// the input side keeps taking transfers while the result side stalls, until
// the queue and the input register are full. Most events are handled in the
// run state alone; an ack with an RTT sample steps on through the SRTT,
// deviation and RTO add-and-clamp states in turn (the very first sample goes
// straight to the RTO state), and no new event is taken until the run state is
// back. Configuration writes take effect at once and are meant for idle periods; no clearing pass follows reset.
module reno_window_and_rto_tracker import rwrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rwrt_event_if.sink            in_ch,
  rwrt_result_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  fr_valid, fr_ready;
  item_t fr_item;
  logic  q_valid, q_ready;
  item_t q_item;

  rwrt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (fr_valid),
    .item       (fr_item),
    .item_ready (fr_ready)
  );

  rwrt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_item  (fr_item),
    .push_ready (fr_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  rwrt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item       (q_item),
    .item_ready (q_ready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ch     (out_ch)
  );

endmodule

// ===== hdl/rwrt_checker.sv =====
// ----------------------------------------------------------------------------
// rwrt_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "reno_window_and_rto_tracker_defines.svh"

module rwrt_checker import rwrt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WIN_W-1:0]  usable_window,
  input logic [WIN_W-1:0]  packets_in_flight,
  input logic [TIME_W-1:0] smoothed_rtt,
  input logic [TIME_W-1:0] send_wait
);

  `RWRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RWRT_ASSERT_NOW(a_win_nonzero, out_valid, usable_window != '0)
  `RWRT_ASSERT_NOW(a_wait_room, out_valid && (packets_in_flight < usable_window), send_wait == '0)
  `RWRT_ASSERT_NOW(a_wait_srtt, out_valid && (packets_in_flight >= usable_window) && (smoothed_rtt != '0), send_wait == smoothed_rtt)

endmodule

bind reno_window_and_rto_tracker rwrt_checker u_rwrt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .usable_window     (out_ch.usable_window),
  .packets_in_flight (out_ch.packets_in_flight),
  .smoothed_rtt      (out_ch.smoothed_rtt),
  .send_wait         (out_ch.send_wait)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for reno_window_and_rto_tracker. Event transfers go in
// with random gaps while the status side stalls at random. A local Reno /
// RTO predictor works out every status transfer, and each one is checked
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import rwrt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;
  localparam int HOLD_CYCLES = 120;

  localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

  typedef struct {
    logic [WIN_W-1:0]  usable_window;
    logic [WIN_W-1:0]  packets_in_flight;
    logic [TIME_W-1:0] smoothed_rtt;
    logic [TIME_W-1:0] retransmit_timeout;
    logic [TIME_W-1:0] send_wait;
    mode_t             cc_mode;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rwrt_event_if  ev_ch();
  rwrt_result_if st_ch();

  reno_window_and_rto_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (ev_ch),
    .out_ch    (st_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor registers and state
  logic [WIN_W-1:0]  rwnd_reg;
  logic [TIME_W-1:0] irtt_reg;
  logic [TIME_W-1:0] rto_cap;
  logic [THR_W-1:0]  dup_thresh;
  logic [TIME_W-1:0] srtt;
  logic [TIME_W-1:0] rttvar;
  logic [TIME_W-1:0] rto;
  logic [WIN_W-1:0]  flight;
  logic [WIN_W-1:0]  cwnd;
  logic [WIN_W-1:0]  wnd;
  logic [WIN_W-1:0]  ssthresh;
  logic [WIN_W-1:0]  dupacks;
  logic [WIN_W-1:0]  acked;
  mode_t             cc;

  status_t expected_status[$];

  int events_sent  = 0;
  int results_seen = 0;
  int fail_count   = 0;
  int cycle_count  = 0;
  int rtt_base     = 1000;
  int hold_left    = 0;
  int stall_left   = 0;
  bit tx_gaps      = 1'b0;
  bit rx_stalls    = 1'b0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [TIME_W-1:0] cap_rto(longint v);
    if (v > longint'(rto_cap)) v = longint'(rto_cap);
    return v[TIME_W-1:0];
  endfunction

  function automatic void reload_rto();
    longint sum;
    rttvar = irtt_reg >> DEV_GAIN_SHIFT;
    sum = longint'(irtt_reg) + 4 * longint'(rttvar);
    rto = (sum > longint'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic void clip_window();
    logic [WIN_W-1:0] rw;
    rw = rwnd_reg;
    if (rw == '0) rw = 1;
    wnd = (cwnd > rw) ? rw : cwnd;
  endfunction

  function automatic void absorb_rtt(logic [TIME_W-1:0] sample);
    longint err;
    longint mag;
    if (srtt == '0) begin
      srtt = sample;
      rttvar = sample >> 1;
    end else begin
      err = longint'(sample) - longint'(srtt);
      mag = (err < 0) ? -err : err;
      srtt = TIME_W'(longint'(srtt) + (err >>> ERR_GAIN_SHIFT));
      rttvar = TIME_W'(longint'(rttvar) + ((mag - longint'(rttvar)) >>> DEV_GAIN_SHIFT));
    end
    rto = cap_rto(longint'(srtt) + 4 * longint'(rttvar));
  endfunction

  function automatic status_t advance_reno_state(logic [ACTION_W-1:0] act,
                                                 logic [TIME_W-1:0] sample);
    status_t s;
    logic [WIN_W:0] t;
    case (act)
      ACT_SEND: if (flight != WIN_MAX) flight++;
      ACT_ACK: begin
        if (flight != '0) flight--;
        if (sample != '0) absorb_rtt(sample);
        dupacks = '0;
        if (acked != WIN_MAX) acked++;
        if (cc == MODE_START || cc == MODE_TIMEOUT) begin
          if (cwnd != WIN_MAX) cwnd++;
          if (cwnd == ssthresh) cc = MODE_NORMAL;
        end else if (cc == MODE_FAST) begin
          cc = MODE_NORMAL;
          cwnd = ssthresh;
        end else if (acked >= cwnd) begin
          acked = '0;
          if (cwnd != WIN_MAX) cwnd++;
        end
        clip_window();
      end
      ACT_LOSS: if (flight != '0) flight--;
      ACT_RETX: begin
        t = wnd >> 1;
        if (t < 2) t = 2;
        ssthresh = t[WIN_W-1:0];
        acked = '0;
        if (cc != MODE_TIMEOUT && cc != MODE_FAST) begin
          cc = MODE_FAST;
          t = t + 3;
          cwnd = (t > WIN_MAX) ? WIN_MAX : t[WIN_W-1:0];
        end
        clip_window();
      end
      ACT_TIMEOUT: begin
        rto = cap_rto(2 * longint'(rto));
        cc = MODE_TIMEOUT;
        cwnd = 1;
        clip_window();
      end
      ACT_DUP: begin
        if (dupacks != WIN_MAX) dupacks++;
        if (dupacks > dup_thresh && cc == MODE_FAST) begin
          if (cwnd != WIN_MAX) cwnd++;
          clip_window();
        end
      end
      default: ;
    endcase
    s.usable_window      = wnd;
    s.packets_in_flight  = flight;
    s.smoothed_rtt       = srtt;
    s.retransmit_timeout = rto;
    s.send_wait          = (flight < wnd) ? '0 : ((srtt != '0) ? srtt : rto);
    s.cc_mode            = cc;
    return s;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REMOTE_WINDOW: rwnd_reg = data[WIN_W-1:0];
      CFG_INITIAL_RTT: begin
        irtt_reg = data;
        if (srtt == '0) reload_rto();
      end
      CFG_MAX_RTO:       rto_cap = data;
      CFG_DUP_THRESHOLD: dup_thresh = data[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_event(logic [ACTION_W-1:0] act, logic [TIME_W-1:0] sample);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    ev_ch.valid      <= 1'b1;
    ev_ch.action     <= act;
    ev_ch.rtt_sample <= sample;
    do @(posedge clk); while (!ev_ch.ready);
    expected_status.push_back(advance_reno_state(act, sample));
    events_sent++;
  endtask

  // block is idle once every predicted status has been seen
  task automatic drain();
    ev_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
  endtask

  function automatic logic [TIME_W-1:0] pick_rtt();
    int spread;
    case ($urandom_range(0, 19))
      0: return '0;
      1: return TIME_W'($urandom());
      2: return TIME_MAX;
      default: begin
        spread = rtt_base / 4;
        return TIME_W'(rtt_base - spread + $urandom_range(0, 2 * spread));
      end
    endcase
  endfunction

  // mostly well-formed flows: window fill and drain, loss recovery, timeout
  task automatic run_flows(int count);
    int start_cnt;
    int k;
    int pick;
    start_cnt = events_sent;
    rtt_base = $urandom_range(20, 400000);
    while (events_sent - start_cnt < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        k = $urandom_range(1, 8);
        repeat (k) send_event(ACT_SEND, TIME_W'($urandom()));
        repeat (k) send_event(($urandom_range(0, 7) == 0) ? ACT_LOSS : ACT_ACK, pick_rtt());
      end else if (pick < 65) begin
        repeat ($urandom_range(0, 6)) send_event(ACT_DUP, TIME_W'($urandom()));
        send_event(ACT_RETX, TIME_W'($urandom()));
        repeat ($urandom_range(0, 10)) send_event(ACT_DUP, TIME_W'($urandom()));
        send_event(ACT_ACK, pick_rtt());
      end else if (pick < 78) begin
        send_event(ACT_TIMEOUT, TIME_W'($urandom()));
        repeat ($urandom_range(1, 6)) send_event(ACT_ACK, pick_rtt());
      end else begin
        repeat ($urandom_range(1, 4))
          send_event(ACTION_W'($urandom_range(0, 7)), TIME_W'($urandom()));
      end
    end
  endtask

  task automatic test_before_first_sample();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_event(ACT_RSVD6, TIME_MAX);
    send_event(ACT_RSVD7, '0);
    send_event(ACT_SEND, '0);
    send_event(ACT_SEND, TIME_MAX);
    drain();
    // reload saturates rto; timeout then clamps it
    write_reg(CFG_INITIAL_RTT, TIME_MAX);
    send_event(ACT_TIMEOUT, '0);
    drain();
    write_reg(CFG_INITIAL_RTT, '0);
    send_event(ACT_TIMEOUT, '0);
    repeat (3) send_event(ACT_LOSS, '0);
    send_event(ACT_ACK, '0);
    drain();
    write_reg(CFG_INITIAL_RTT, 24'd1000000);
  endtask

  task automatic test_directed_events();
    write_reg(CFG_REMOTE_WINDOW, CFG_DATA_W'(WIN_MAX));
    send_event(ACT_RETX, '0);
    send_event(ACT_TIMEOUT, '0);
    send_event(ACT_ACK, TIME_MAX);
    send_event(ACT_ACK, 24'd1);
    send_event(ACT_RETX, '0);
    repeat (4) send_event(ACT_DUP, '0);
    send_event(ACT_ACK, 24'h555555);
    send_event(ACT_ACK, 24'hAAAAAA);
    send_event(ACT_TIMEOUT, '0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_REMOTE_WINDOW, '0);
    write_reg(CFG_MAX_RTO, '0);
    write_reg(CFG_DUP_THRESHOLD, '0);
    write_reg(CFG_INITIAL_RTT, TIME_MAX);
    run_flows(40);
    drain();
    write_reg(CFG_REMOTE_WINDOW, CFG_DATA_W'(WIN_MAX));
    write_reg(CFG_MAX_RTO, TIME_MAX);
    write_reg(CFG_DUP_THRESHOLD, 24'd255);
    write_reg(CFG_INITIAL_RTT, '0);
    run_flows(40);
    drain();
    write_reg(CFG_REMOTE_WINDOW, 24'd1);
    write_reg(CFG_MAX_RTO, 24'd1);
    write_reg(CFG_DUP_THRESHOLD, 24'd1);
    run_flows(40);
    drain();
  endtask

  // status side holds off while events keep coming, filling the block
  task automatic test_backpressure();
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    run_flows(40);
    drain();
  endtask

  task automatic test_random_flows();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      write_reg(CFG_REMOTE_WINDOW, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                $urandom_range(256, 65535) : $urandom_range(1, 40)));
      write_reg(CFG_MAX_RTO, CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                $urandom_range(1, 100000) : $urandom_range(100000, 16777215)));
      write_reg(CFG_DUP_THRESHOLD, CFG_DATA_W'($urandom_range(0, 8)));
      write_reg(CFG_INITIAL_RTT, TIME_W'($urandom()));
      tx_gaps   = (phase < 4);
      rx_stalls = (phase < 4);
      run_flows(130);
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      st_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      st_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      st_ch.ready <= 1'b0;
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      st_ch.ready <= 1'b0;
      stall_left--;
    end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
      st_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      st_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("status %0d %s: expected %0d, got %0d", results_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : status_check
    status_t want;
    if (rst_n && st_ch.valid && st_ch.ready) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("status %0d with no pending event: window %0d, in flight %0d",
                   results_seen, st_ch.usable_window, st_ch.packets_in_flight);
      end else begin
        want = expected_status[0];
        expected_status.delete(0);
        check_field("usable_window", st_ch.usable_window, want.usable_window);
        check_field("packets_in_flight", st_ch.packets_in_flight, want.packets_in_flight);
        check_field("smoothed_rtt", st_ch.smoothed_rtt, want.smoothed_rtt);
        check_field("retransmit_timeout", st_ch.retransmit_timeout, want.retransmit_timeout);
        check_field("send_wait", st_ch.send_wait, want.send_wait);
        check_field("cc_mode", st_ch.cc_mode, want.cc_mode);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    ev_ch.valid      <= 1'b0;
    ev_ch.action     <= '0;
    ev_ch.rtt_sample <= '0;
    rwnd_reg   = 16'd2;
    irtt_reg   = 24'd1000000;
    rto_cap    = 24'd3000000;
    dup_thresh = 8'd3;
    srtt       = '0;
    reload_rto();
    flight     = '0;
    cwnd       = 16'd1;
    wnd        = 16'd1;
    ssthresh   = '0;
    cc         = MODE_START;
    dupacks    = '0;
    acked      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_first_sample();
    test_directed_events();
    test_register_extremes();
    test_backpressure();
    test_random_flows();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rwrt_pkg.sv
hdl/rwrt_event_if.sv
hdl/rwrt_front.sv
hdl/rwrt_fifo.sv
hdl/rwrt_back.sv
hdl/reno_window_and_rto_tracker.sv
hdl/rwrt_checker.sv
tb/sv/testbench.sv
